[src/wbps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int LEN_W       = 5;
  localparam int CARE_W      = 16;
  localparam int ADDR_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int DISP_W      = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]         CALL_OPCODE = 8'hE8;
  localparam logic [LEN_W-1:0]   CALL_SPAN   = LEN_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_RELATIVE     = 3'd4,
    REG_IMAGE_BASE   = 3'd5
  } cfg_reg_t;

  // pattern settings seen by the front end
  typedef struct packed {
    logic [63:0]       pattern_low;
    logic [63:0]       pattern_high;
    logic [CARE_W-1:0] care;
    logic [LEN_W-1:0]  len;
    logic              relative;
  } cfg_t;

  // one scan outcome queued between front and back
  typedef struct packed {
    logic               found;
    logic               rel;
    logic [COUNT_W-1:0] offset;
    logic [DISP_W-1:0]  disp;
  } scan_evt_t;

endpackage
`default_nettype wire

[src/wildcard_byte_pattern_scanner.sv]
`default_nettype none
// A result passes through a queue slot and the output register before it is shown.
// Throughput: one byte per cycle; the front compare and the queue run every cycle.
// A held output stalls the front only once the two-entry queue is full.
// Reset clears the window, byte count, queue and output valid, and sets the
// pattern length to 1 with all other configuration registers zero.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams a memory image, finds the first wildcard pattern match and reports
// its address or the call target it encodes.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner import wbps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       found,
  output logic [ADDR_W-1:0]          result_address
);

  cfg_t              cfg;
  logic [ADDR_W-1:0] image_base;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  scan_evt_t         push_evt;
  scan_evt_t         pop_evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low  <= '0;
      cfg.pattern_high <= '0;
      cfg.care         <= '0;
      cfg.len          <= LEN_W'(1);
      cfg.relative     <= 1'b0;
      image_base       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:  cfg.pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: cfg.pattern_high <= cfg_data;
        REG_CARE_MASK:    cfg.care         <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LEN:  cfg.len          <= cfg_data[LEN_W-1:0];
        REG_RELATIVE:     cfg.relative     <= cfg_data[0];
        REG_IMAGE_BASE:   image_base       <= cfg_data;
        default: ;
      endcase
    end
  end

  wbps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .evt       (push_evt)
  );

  wbps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_evt),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_evt),
    .empty     (q_empty)
  );

  wbps_back u_back (
    .clk            (clk),
    .rst            (rst),
    .image_base     (image_base),
    .q_empty        (q_empty),
    .q_data         (pop_evt),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .result_address (result_address)
  );

endmodule
`default_nettype wire

[src/wbps_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_front
// Takes image bytes, shifts the window and runs the masked compare; queues
// a match or an end-of-image miss.
// ----------------------------------------------------------------------------
module wbps_front import wbps_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic      last_byte,
  input  wire logic      q_full,
  output logic           push,
  output scan_evt_t      evt
);

  logic [7:0]         window [PATTERN_MAX];
  logic [7:0]         win_shift [PATTERN_MAX];
  logic [COUNT_W-1:0] bytes_seen;
  logic [COUNT_W-1:0] seen_next;
  logic               match_reported;

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   span;
  logic               rel;
  logic               hit;
  logic               accept;
  logic [127:0]       pattern_bytes;

  assign in_ready      = !q_full;
  assign accept        = in_valid && in_ready;
  assign pattern_bytes = {cfg.pattern_high, cfg.pattern_low};

  // effective length, call-target mode and span
  always_comb begin
    len = cfg.len;
    if (cfg.len == '0) begin
      len = LEN_W'(1);
    end else if (cfg.len > LEN_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end
    rel  = cfg.relative || (cfg.care[0] && (pattern_bytes[7:0] == CALL_OPCODE));
    span = (rel && (len < CALL_SPAN)) ? CALL_SPAN : len;
  end

  always_comb begin
    win_shift[0] = data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_shift[k] = window[k-1];
    end
    seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + COUNT_W'(1);
  end

  // masked compare, one lane per pattern byte
  always_comb begin
    logic            ok;
    logic [LEN_W-1:0] pos;
    ok  = 1'b1;
    pos = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pos = span - LEN_W'(j) - LEN_W'(1);
      if ((LEN_W'(j) < len) && cfg.care[j] &&
          (win_shift[pos[WIN_IDX_W-1:0]] != pattern_bytes[8*j +: 8])) begin
        ok = 1'b0;
      end
    end
    hit = !match_reported && (seen_next >= COUNT_W'(span)) && ok;
  end

  always_comb begin
    logic [LEN_W-1:0] p2, p3, p4, p5;
    p2 = span - LEN_W'(2);
    p3 = span - LEN_W'(3);
    p4 = span - LEN_W'(4);
    p5 = span - LEN_W'(5);
    evt.found  = hit;
    evt.rel    = rel;
    evt.offset = seen_next - COUNT_W'(span);
    evt.disp   = {win_shift[p5[WIN_IDX_W-1:0]], win_shift[p4[WIN_IDX_W-1:0]],
                  win_shift[p3[WIN_IDX_W-1:0]], win_shift[p2[WIN_IDX_W-1:0]]};
    push       = accept && (hit || (last_byte && !match_reported));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= '0;
      end
    end else if (accept) begin
      if (last_byte) begin
        // end of image: start afresh
        bytes_seen     <= '0;
        match_reported <= 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
          window[k] <= '0;
        end
      end else if (!match_reported) begin
        bytes_seen     <= seen_next;
        match_reported <= hit;
        for (int k = 0; k < PATTERN_MAX; k++) begin
          window[k] <= win_shift[k];
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/wbps_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_queue
// Short queue of scan outcomes between front end and address stage.
// ----------------------------------------------------------------------------
module wbps_queue import wbps_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire scan_evt_t push_data,
  output logic           full,
  input  wire logic      pop,
  output scan_evt_t      pop_data,
  output logic           empty
);

  scan_evt_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/wbps_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_back
// Turns a queued outcome into the reported address and holds it in the
// output register until taken.
// ----------------------------------------------------------------------------
module wbps_back import wbps_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] image_base,
  input  wire logic              q_empty,
  input  wire scan_evt_t         q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   found,
  output logic [ADDR_W-1:0]      result_address
);

  logic [ADDR_W-1:0] addend;
  logic [ADDR_W-1:0] addr_next;

  assign pop = !q_empty && (!out_valid || out_ready);

  // call target adds 5 plus the sign-extended displacement
  always_comb begin
    addend = '0;
    if (q_data.rel) begin
      addend = {{(ADDR_W-DISP_W){q_data.disp[DISP_W-1]}}, q_data.disp} + ADDR_W'(5);
    end
    addr_next = '0;
    if (q_data.found) begin
      addr_next = image_base + {{(ADDR_W-COUNT_W){1'b0}}, q_data.offset} + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      found          <= q_data.found;
      result_address <= addr_next;
    end
  end

endmodule
`default_nettype wire

[src/wbps_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module wbps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        found,
  input wire logic [63:0] result_address
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(result_address))
    else $error("result changed while stalled");

  // a miss carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> result_address == 64'd0)
    else $error("not-found result with non-zero address");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the queue, so input is open
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
`default_nettype wire

[bench/wildcard_byte_pattern_scanner_test.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_test
// Streams byte images through the scanner under random handshake pressure and
// checks every reported match, call target and not-found outcome against a
// cycle-free model of the scan kept in the bench.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_test;

  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int BYTE_TARGET = 850;
  localparam int QUIET_TAIL  = 90;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = 8'h00;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  found;
  logic [ADDR_W-1:0]     result_address;

  wildcard_byte_pattern_scanner DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .result_address (result_address)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // scan model: registers, window and per-image state
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic        found;
    logic [63:0] addr;
  } outcome_t;

  outcome_t results_due[$];

  logic [63:0] pat_lo, pat_hi, image_base_q;
  logic [15:0] care_q;
  logic [4:0]  plen_q;
  logic        rel_q;
  logic [7:0]  win [PATTERN_MAX];
  logic [31:0] seen;
  bit          hit_done;

  int errors = 0;
  int fed = 0;
  int sent = 0;
  int checked = 0;
  int hits = 0;
  int phases = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  function automatic int used_len();
    if (plen_q == 0) return 1;
    if (plen_q > PATTERN_MAX) return PATTERN_MAX;
    return int'(plen_q);
  endfunction

  function automatic bit call_form();
    return rel_q || (care_q[0] && pat_lo[7:0] == CALL_OPCODE);
  endfunction

  task automatic clear_image();
    foreach (win[k]) win[k] = 8'h00;
    seen = '0;
    hit_done = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] d, input bit last, output bit has_res,
                           output outcome_t res);
    int len, span;
    bit ok, is_call;
    logic [127:0] pat;
    logic [31:0] disp;
    has_res = 1'b0;
    res = '0;
    if (!hit_done) begin
      for (int k = PATTERN_MAX - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = d;
      if (seen != 32'hFFFF_FFFF) seen = seen + 1;
      len = used_len();
      is_call = call_form();
      pat = {pat_hi, pat_lo};
      span = (is_call && len < 5) ? 5 : len;
      if (seen >= 32'(span)) begin
        ok = 1'b1;
        for (int j = 0; j < len; j++)
          if (care_q[j] && win[span-1-j] != pat[j*8 +: 8]) ok = 1'b0;
        if (ok) begin
          res.addr = image_base_q + {32'd0, seen - 32'(span)};
          if (is_call) begin
            disp = {win[span-5], win[span-4], win[span-3], win[span-2]};
            res.addr = res.addr + 64'd5 + {{32{disp[31]}}, disp};
          end
          res.found = 1'b1;
          has_res = 1'b1;
          hit_done = 1'b1;
        end
      end
    end
    if (last) begin
      if (!hit_done) begin
        has_res = 1'b1;
        res = '0;
      end
      clear_image();
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // write one register; the caller or the next transaction lowers the enable
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PATTERN_LOW:  pat_lo = val;
      REG_PATTERN_HIGH: pat_hi = val;
      REG_CARE_MASK:    care_q = val[15:0];
      REG_PATTERN_LEN:  plen_q = val[4:0];
      REG_RELATIVE:     rel_q = val[0];
      REG_IMAGE_BASE:   image_base_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input bit last, input bit typed,
                           input outcome_t typed_res);
    int gap;
    bit has_res;
    outcome_t res;
    if (cfg_we) cfg_we <= 1'b0;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent++;
    if (!hit_done) fed++;
    scan_byte(d, last, has_res, res);
    if (typed) begin
      has_res = 1'b1;
      res = typed_res;
    end
    if (has_res) results_due.push_back(res);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic new_settings();
    logic [63:0] lo, hi, base_v, mask_v, len_v, rel_v;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    mask_v = {$urandom, $urandom};
    len_v = {$urandom, $urandom};
    rel_v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: mask_v[15:0] = 16'h0000;
      1: mask_v[15:0] = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: len_v[4:0] = 5'd0;
      1: len_v[4:0] = 5'($urandom_range(17, 31));
      2: len_v[4:0] = 5'd16;
      3: len_v[4:0] = 5'd1;
      default: len_v[4:0] = 5'($urandom_range(2, 15));
    endcase
    // bias towards the call opcode so the call target path is reached often
    if ($urandom_range(0, 3) == 0) begin
      lo[7:0] = CALL_OPCODE;
      mask_v[0] = 1'b1;
    end
    case ($urandom_range(0, 3))
      0: base_v = 64'd0;
      1: base_v = '1;
      default: base_v = {$urandom, $urandom};
    endcase
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, mask_v);
    write_reg(REG_PATTERN_LEN, len_v);
    write_reg(REG_RELATIVE, rel_v);
    write_reg(REG_IMAGE_BASE, base_v);
    phases++;
  endtask

  // plant the pattern (sometimes with one cared byte broken) in random
  // surroundings, or send plain noise
  task automatic send_image();
    int len, span, lead, tail, kind, j, n;
    bit keep_open;
    logic [127:0] pat;
    logic [7:0] img[$];
    int cared[$];
    len = used_len();
    span = (call_form() && len < 5) ? 5 : len;
    pat = {pat_hi, pat_lo};
    kind = $urandom_range(0, 9);
    lead = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (n = 0; n < lead; n++) img.push_back(8'($urandom));
    if (kind <= 7) begin
      for (j = 0; j < span; j++) begin
        if (j < len && care_q[j]) begin
          img.push_back(pat[j*8 +: 8]);
          cared.push_back(j);
        end else begin
          img.push_back(8'($urandom));
        end
      end
      if (kind >= 6 && cared.size() > 0) begin
        j = cared[$urandom_range(0, cared.size() - 1)];
        img[lead+j] = img[lead+j] ^ 8'($urandom_range(1, 255));
      end
      tail = $urandom_range(0, 6);
    end else begin
      tail = $urandom_range(1, 30);
    end
    for (n = 0; n < tail; n++) img.push_back(8'($urandom));
    // leave the image open now and then so the next settings apply mid-image
    keep_open = ($urandom_range(0, 9) == 0);
    foreach (img[n])
      send_byte(img[n], !keep_open && n == img.size() - 1, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random bursts of out_ready stall cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  outcome_t head;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none outstanding, expected none, actual found=%0b addr=%h",
                 $time, found, result_address);
      end else begin
        head = results_due.pop_front();
        checked++;
        if (head.found) hits++;
        if (found !== head.found) begin
          errors++;
          $display("%0t: found mismatch, expected %0b, actual %0b", $time, head.found, found);
        end
        if (result_address !== head.addr) begin
          errors++;
          $display("%0t: result_address mismatch, expected %h, actual %h",
                   $time, head.addr, result_address);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit          is_write;
    cfg_reg_t    reg_idx;
    logic [63:0] value;
    logic [7:0]  d;
    bit          last;
    bit          typed;
    outcome_t    res;
  } row_t;

  row_t script[$];

  function automatic row_t reg_row(cfg_reg_t idx, logic [63:0] val);
    row_t r;
    r = '{reg_idx: REG_PATTERN_LOW, default: '0};
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic row_t byte_row(logic [7:0] d, bit last);
    row_t r;
    r = '{reg_idx: REG_PATTERN_LOW, default: '0};
    r.d = d;
    r.last = last;
    return r;
  endfunction

  function automatic row_t known_row(logic [7:0] d, bit last, bit f, logic [63:0] a);
    row_t r;
    r = byte_row(d, last);
    r.typed = 1'b1;
    r.res = '{found: f, addr: a};
    return r;
  endfunction

  initial begin
    bit after_byte;
    int n_img;

    // reset settings: one wildcard byte, so the very first byte matches at 0
    script.push_back(known_row(8'h00, 1'b0, 1'b1, 64'd0));
    script.push_back(byte_row(8'hFF, 1'b1));
    // sixteen cared bytes cannot fit a three-byte image
    script.push_back(reg_row(REG_PATTERN_LOW, '1));
    script.push_back(reg_row(REG_PATTERN_HIGH, 64'd0));
    script.push_back(reg_row(REG_CARE_MASK, 64'hFFFF));
    script.push_back(reg_row(REG_PATTERN_LEN, 64'd16));
    script.push_back(reg_row(REG_IMAGE_BASE, '1));
    script.push_back(byte_row(8'hFF, 1'b0));
    script.push_back(byte_row(8'hFF, 1'b0));
    script.push_back(known_row(8'hFF, 1'b1, 1'b0, 64'd0));
    // call opcode in byte 0: span widens to five, displacement -1,
    // and the final byte completes the match
    script.push_back(reg_row(REG_PATTERN_LOW, 64'h0000_0000_0000_00E8));
    script.push_back(reg_row(REG_CARE_MASK, 64'h0001));
    script.push_back(reg_row(REG_PATTERN_LEN, 64'd1));
    script.push_back(reg_row(REG_IMAGE_BASE, 64'hFFFF_FFFF_FFFF_FFF0));
    script.push_back(byte_row(8'h00, 1'b0));
    script.push_back(byte_row(8'hE8, 1'b0));
    script.push_back(byte_row(8'hFF, 1'b0));
    script.push_back(byte_row(8'hFF, 1'b0));
    script.push_back(byte_row(8'hFF, 1'b0));
    script.push_back(byte_row(8'hFF, 1'b1));
    // forced relative mode with a zero length, positive displacement
    script.push_back(reg_row(REG_PATTERN_LEN, 64'd0));
    script.push_back(reg_row(REG_RELATIVE, 64'd1));
    script.push_back(reg_row(REG_CARE_MASK, 64'd0));
    script.push_back(reg_row(REG_IMAGE_BASE, 64'd0));
    script.push_back(byte_row(8'h11, 1'b0));
    script.push_back(byte_row(8'h78, 1'b0));
    script.push_back(byte_row(8'h56, 1'b0));
    script.push_back(byte_row(8'h34, 1'b0));
    script.push_back(byte_row(8'h12, 1'b0));
    script.push_back(byte_row(8'h00, 1'b1));
    // call opcode found but the displacement runs past the end of the image
    script.push_back(reg_row(REG_RELATIVE, 64'd0));
    script.push_back(reg_row(REG_PATTERN_LEN, 64'd2));
    script.push_back(reg_row(REG_CARE_MASK, 64'd1));
    script.push_back(byte_row(8'hE8, 1'b0));
    script.push_back(byte_row(8'h01, 1'b0));
    script.push_back(known_row(8'h02, 1'b1, 1'b0, 64'd0));

    pat_lo = '0;
    pat_hi = '0;
    care_q = '0;
    plen_q = 5'd1;
    rel_q = 1'b0;
    image_base_q = '0;
    clear_image();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    after_byte = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_write) begin
        if (after_byte) settle();
        write_reg(script[i].reg_idx, script[i].value);
        after_byte = 1'b0;
      end else begin
        send_byte(script[i].d, script[i].last, script[i].typed, script[i].res);
        after_byte = 1'b1;
      end
    end

    while (sent < BYTE_TARGET) begin
      settle();
      new_settings();
      n_img = $urandom_range(2, 8);
      repeat (n_img) begin
        idle_on = (sent < BYTE_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
        send_image();
        if ($urandom_range(0, 11) == 0) settle();
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Scanned %0d bytes (%0d searched) over %0d register settings;", sent, fed, phases);
    $display("checked %0d outcomes, %0d of them matches or call targets.", checked, hits);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
